// ===== design/wsu_pkg.sv =====
// Shared types and constants for the wave stencil update block.
// No dependencies; imported by every module of the block but wsu_ram.
`default_nettype none
package wsu_pkg;

	localparam int WIN_DEPTH  = 4097;
	localparam int WIN_AW     = 13;
	localparam int DLY_DEPTH  = 2048;
	localparam int DLY_AW     = 11;
	localparam int MAX_HEIGHT = 1024;
	localparam int MIN_HEIGHT = 5;

	// configuration register indexes
	localparam logic [2:0] REG_GRID_HEIGHT   = 3'd0;
	localparam logic [2:0] REG_FIRST_COL     = 3'd1;
	localparam logic [2:0] REG_END_COL       = 3'd2;
	localparam logic [2:0] REG_FIRST_ROW     = 3'd3;
	localparam logic [2:0] REG_END_ROW       = 3'd4;
	localparam logic [2:0] REG_NEAR_WEIGHT   = 3'd5;
	localparam logic [2:0] REG_CENTRE_WEIGHT = 3'd6;
	localparam logic [2:0] REG_SELF_WEIGHT   = 3'd7;

	// window tap select: centre, four near, three far (leading sample is added up front)
	localparam logic [2:0] TAP_CENTRE     = 3'd0;
	localparam logic [2:0] TAP_NEAR_UP    = 3'd1;
	localparam logic [2:0] TAP_NEAR_DOWN  = 3'd2;
	localparam logic [2:0] TAP_NEAR_LEFT  = 3'd3;
	localparam logic [2:0] TAP_NEAR_RIGHT = 3'd4;
	localparam logic [2:0] TAP_FAR_UP     = 3'd5;
	localparam logic [2:0] TAP_FAR_DOWN   = 3'd6;
	localparam logic [2:0] TAP_FAR_LEFT   = 3'd7;

	typedef struct packed {
		logic              clr;       // clearing pass write
		logic [WIN_AW-1:0] clr_addr;
		logic              accept;    // item taken this cycle
		logic [2:0]        rd_sel;    // window tap being addressed
		logic              acc_en;    // tap data arrives
		logic [2:0]        acc_sel;
		logic              dly_upd;   // capture delayed sample, write new one
		logic              adv;       // advance line heads
		logic              mul_lo;
		logic              mul_hi;
		logic              emit;      // load output register
	} cmd_t;

	typedef struct packed {
		logic item_ok;   // centre inside the update window
		logic out_free;  // output register can take a result
	} status_t;

endpackage
`default_nettype wire

// ===== design/wave_stencil_update.sv =====
// Top level of the streamed fourth-order 2D wave stencil update.
// Depends on wsu_pkg, wsu_ctrl, wsu_datapath (which holds the wsu_ram line memories).
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  tdata: current, previous, velocity
// m_*       out        m_tvalid/m_tready  tdata: pressure, row, col; tuser: saturated
// cfg_*     in         cfg_valid/cfg_ready index 0..7, data
//
// An item passes through accept, the eight window taps read one per cycle
// through the single read port of the window memory, the split velocity
// multiply and emit. After reset a clearing pass zeroes the line
// memories before the first item is taken; config writes are taken at any time.
// A result waiting in the output register stalls only the next item's emit step.
`default_nettype none
module wave_stencil_update import wsu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [87:0] s_tdata,   // current_sample, previous_sample, velocity_factor
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // new_pressure, row_index, col_index, zero pad
	output logic             m_tuser,   // saturated
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	cmd_t        cmd;
	status_t     status;
	logic [31:0] new_pressure;
	logic [9:0]  row_index;
	logic [15:0] col_index;

	assign cfg_ready = 1'b1;

	wsu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	wsu_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_valid),
		.cfg_idx        (cfg_index),
		.cfg_wdata      (cfg_data),
		.current_sample (s_tdata[31:0]),
		.previous_sample(s_tdata[63:32]),
		.velocity_factor(s_tdata[87:64]),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.new_pressure   (new_pressure),
		.row_index      (row_index),
		.col_index      (col_index),
		.saturated      (m_tuser)
	);

	assign m_tdata = {6'd0, col_index, row_index, new_pressure};

endmodule
`default_nettype wire

// ===== design/wsu_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module wsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/wsu_ctrl.sv =====
// Sequencer for the wave stencil update: clearing pass, tap reads, multiply, emit.
// Depends on wsu_pkg.
`default_nettype none
module wsu_ctrl import wsu_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_TAPS   = 3'd2;
	localparam logic [2:0] ST_MUL_LO = 3'd3;
	localparam logic [2:0] ST_MUL_HI = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0]        state_q;
	logic [WIN_AW-1:0] cnt_q;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr      = 1'b1;
				cmd.clr_addr = cnt_q;
			end
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_TAPS: begin
				cmd.rd_sel  = cnt_q[2:0];
				cmd.acc_en  = cnt_q != '0;
				cmd.acc_sel = cnt_q[2:0] - 3'd1;
				cmd.dly_upd = cnt_q == WIN_AW'(1);
				cmd.adv     = cnt_q == WIN_AW'(8);
			end
			ST_MUL_LO: cmd.mul_lo = 1'b1;
			ST_MUL_HI: cmd.mul_hi = 1'b1;
			ST_EMIT:   cmd.emit   = status.item_ok & status.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (cnt_q == WIN_AW'(WIN_DEPTH - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + WIN_AW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= ST_TAPS;
					end
				end
				ST_TAPS: begin
					if (cnt_q == WIN_AW'(8)) begin
						cnt_q   <= '0;
						state_q <= ST_MUL_LO;
					end else begin
						cnt_q <= cnt_q + WIN_AW'(1);
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (!status.item_ok || status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/wsu_datapath.sv =====
// Datapath: config registers, line memories, stencil accumulate, rounding multiply,
// saturation and the output register. Depends on wsu_pkg and wsu_ram.
`default_nettype none
module wsu_datapath import wsu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output status_t          status,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic [31:0] current_sample,
	input  wire logic [31:0] previous_sample,
	input  wire logic [23:0] velocity_factor,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      new_pressure,
	output logic [9:0]       row_index,
	output logic [15:0]      col_index,
	output logic             saturated
);

	logic [10:0] grid_height_q, end_row_q;
	logic [15:0] first_col_q, end_col_q;
	logic [9:0]  first_row_q;
	logic [7:0]  near_weight_q, centre_weight_q;
	logic [3:0]  self_weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_height_q   <= 11'd1024;
			first_col_q     <= 16'd2;
			end_col_q       <= 16'd65533;
			first_row_q     <= 10'd2;
			end_row_q       <= 11'd1022;
			near_weight_q   <= 8'd16;
			centre_weight_q <= 8'hC4;
			self_weight_q   <= 4'd2;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GRID_HEIGHT:   grid_height_q   <= cfg_wdata[10:0];
				REG_FIRST_COL:     first_col_q     <= cfg_wdata;
				REG_END_COL:       end_col_q       <= cfg_wdata;
				REG_FIRST_ROW:     first_row_q     <= cfg_wdata[9:0];
				REG_END_ROW:       end_row_q       <= cfg_wdata[10:0];
				REG_NEAR_WEIGHT:   near_weight_q   <= cfg_wdata[7:0];
				REG_CENTRE_WEIGHT: centre_weight_q <= cfg_wdata[7:0];
				REG_SELF_WEIGHT:   self_weight_q   <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// clamped column height and its multiples
	logic [10:0]       h;
	logic [WIN_AW-1:0] h1, h2, h3, h4, tap_d;
	always_comb begin
		if (grid_height_q < 11'(MIN_HEIGHT)) h = 11'(MIN_HEIGHT);
		else if (grid_height_q > 11'(MAX_HEIGHT)) h = 11'(MAX_HEIGHT);
		else h = grid_height_q;
		h1 = {2'b00, h};
		h2 = {1'b0, h, 1'b0};
		h3 = h2 + h1;
		h4 = {h, 2'b00};
		case (cmd.rd_sel)
			TAP_CENTRE:     tap_d = h2;
			TAP_NEAR_UP:    tap_d = h2 + WIN_AW'(1);
			TAP_NEAR_DOWN:  tap_d = h2 - WIN_AW'(1);
			TAP_NEAR_LEFT:  tap_d = h3;
			TAP_NEAR_RIGHT: tap_d = h1;
			TAP_FAR_UP:     tap_d = h2 + WIN_AW'(2);
			TAP_FAR_DOWN:   tap_d = h2 - WIN_AW'(2);
			TAP_FAR_LEFT:   tap_d = h4;
			default:        tap_d = h4;
		endcase
	end

	logic [WIN_AW-1:0] win_head_q;
	logic [DLY_AW-1:0] dly_head_q;
	logic [WIN_AW:0]   win_sum;
	logic [WIN_AW-1:0] win_raddr;
	logic [DLY_AW-1:0] dly_raddr;
	always_comb begin
		win_sum = {1'b0, win_head_q} + (WIN_AW+1)'(WIN_DEPTH) - {1'b0, tap_d};
		if (win_sum >= (WIN_AW+1)'(WIN_DEPTH)) win_sum = win_sum - (WIN_AW+1)'(WIN_DEPTH);
		win_raddr = win_sum[WIN_AW-1:0];
		dly_raddr = dly_head_q - h2[DLY_AW-1:0];
	end

	logic [31:0] p_in_q;
	logic [23:0] v_in_q;
	logic [31:0] win_rdata, prev_rdata;
	logic [23:0] vel_rdata;
	logic        clr_dly;
	assign clr_dly = cmd.clr && (cmd.clr_addr < WIN_AW'(DLY_DEPTH));

	wsu_ram #(.WIDTH(32), .DEPTH(WIN_DEPTH)) u_win (
		.clk  (clk),
		.we   (cmd.clr | cmd.accept),
		.waddr(cmd.clr ? cmd.clr_addr : win_head_q),
		.wdata(cmd.clr ? 32'd0 : current_sample),
		.raddr(win_raddr),
		.rdata(win_rdata)
	);

	wsu_ram #(.WIDTH(32), .DEPTH(DLY_DEPTH)) u_prev (
		.clk  (clk),
		.we   (clr_dly | cmd.dly_upd),
		.waddr(cmd.clr ? cmd.clr_addr[DLY_AW-1:0] : dly_head_q),
		.wdata(cmd.clr ? 32'd0 : p_in_q),
		.raddr(dly_raddr),
		.rdata(prev_rdata)
	);

	wsu_ram #(.WIDTH(24), .DEPTH(DLY_DEPTH)) u_vel (
		.clk  (clk),
		.we   (clr_dly | cmd.dly_upd),
		.waddr(cmd.clr ? cmd.clr_addr[DLY_AW-1:0] : dly_head_q),
		.wdata(cmd.clr ? 24'd0 : v_in_q),
		.raddr(dly_raddr),
		.rdata(vel_rdata)
	);

	// position counters and window check
	logic [9:0]  row_q, item_row_q;
	logic [15:0] col_q, item_col_q, ccol;
	logic        item_ok_q, in_win;
	always_comb begin
		ccol   = col_q - 16'd2;
		in_win = (col_q >= 16'd2) && (ccol >= first_col_q) && (ccol < end_col_q)
			&& (row_q >= first_row_q) && ({1'b0, row_q} < end_row_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_head_q <= '0;
			dly_head_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
			item_ok_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				item_ok_q <= in_win;
				if ({1'b0, row_q} + 11'd1 >= h) begin
					row_q <= '0;
					col_q <= col_q + 16'd1;
				end else begin
					row_q <= row_q + 10'd1;
				end
			end
			if (cmd.adv) begin
				win_head_q <= (win_head_q == WIN_AW'(WIN_DEPTH - 1)) ? '0
					: win_head_q + WIN_AW'(1);
				dly_head_q <= dly_head_q + DLY_AW'(1);
			end
		end
	end

	// stencil accumulate: acc = near*N - F + centre_w*c, leading sample seeds -F
	logic signed [43:0] acc_q;
	logic signed [31:0] c_q, pc_q;
	logic [23:0]        vc_q;
	logic signed [7:0]  coef;
	logic signed [39:0] tap_prod;
	always_comb begin
		if (cmd.acc_sel == TAP_CENTRE) coef = centre_weight_q;
		else if (cmd.acc_sel <= TAP_NEAR_RIGHT) coef = near_weight_q;
		else coef = -8'sd1;
		tap_prod = coef * $signed(win_rdata);
	end

	// rounding multiply by velocity, split in a low and a high partial product
	logic [45:0]        plo_q;
	logic signed [46:0] phi;
	logic [69:0]        rsum;
	logic signed [45:0] rnd_q;
	assign phi  = $signed(acc_q[43:22]) * $signed({1'b0, vc_q});
	assign rsum = {phi[46], phi, 22'd0} + {24'd0, plo_q} + 70'd8388608;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_row_q <= row_q;
			item_col_q <= ccol;
			p_in_q     <= previous_sample;
			v_in_q     <= velocity_factor;
			acc_q      <= -{{12{current_sample[31]}}, current_sample};
		end
		if (cmd.acc_en) begin
			acc_q <= acc_q + {{4{tap_prod[39]}}, tap_prod};
			if (cmd.acc_sel == TAP_CENTRE) c_q <= win_rdata;
		end
		if (cmd.dly_upd) begin
			pc_q <= prev_rdata;
			vc_q <= vel_rdata;
		end
		if (cmd.mul_lo) plo_q <= 46'(acc_q[21:0]) * 46'(vc_q);
		if (cmd.mul_hi) rnd_q <= rsum[69:24];
	end

	// time extrapolation and saturation
	logic signed [35:0] swc;
	logic signed [47:0] r;
	logic [31:0]        res;
	logic               sat;
	always_comb begin
		swc = $signed(self_weight_q) * c_q;
		r   = {{2{rnd_q[45]}}, rnd_q} + {{12{swc[35]}}, swc} - {{16{pc_q[31]}}, pc_q};
		sat = 1'b0;
		res = r[31:0];
		if (!r[47] && (r[46:31] != '0)) begin
			res = 32'h7FFF_FFFF;
			sat = 1'b1;
		end else if (r[47] && (r[46:31] != '1)) begin
			res = 32'h8000_0000;
			sat = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			new_pressure <= res;
			row_index    <= item_row_q;
			col_index    <= item_col_q;
			saturated    <= sat;
		end
	end

	assign status.item_ok  = item_ok_q;
	assign status.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== verif/tb_wave_stencil_update.sv =====
// Self-checking testbench for wave_stencil_update: random and directed grid items
// are checked against a built-in stencil predictor. Depends on wsu_pkg and the RTL.
`default_nettype none
module tb_wave_stencil_update;
	import wsu_pkg::*;

	typedef struct {
		logic [31:0] pressure;
		logic [9:0]  row;
		logic [15:0] col;
		logic        sat;
	} stencil_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;   // current_sample, previous_sample, velocity_factor
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // new_pressure, row_index, col_index, zero pad
	logic        m_tuser;   // saturated
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	wave_stencil_update DUT (.*);

	// predictor state
	longint            win_line [WIN_DEPTH];
	longint            prev_line [DLY_DEPTH];
	longint            vel_line [DLY_DEPTH];
	int                win_head, dly_head, row_ctr, col_ctr;
	logic [10:0]       grid_height, end_row;
	logic [15:0]       first_col, end_col;
	logic [9:0]        first_row;
	logic signed [7:0] near_weight, centre_weight;
	logic signed [3:0] self_weight;

	stencil_result_t   pending_updates [$];
	int                errors = 0;
	bit                tx_steady = 0;   // no sender gaps
	bit                rx_steady = 0;   // no receiver stalls
	int                rx_long_hold = 0;

	always #5 clk = ~clk;

	function automatic longint win_tap(input int d);
		return win_line[(win_head + WIN_DEPTH - d) % WIN_DEPTH];
	endfunction

	function automatic bit stencil_update(input logic [31:0] cur, input logic [31:0] prv,
			input logic [23:0] vel, output stencil_result_t res);
		int     h, didx, row, col;
		longint c, pc, vd, near_sum, far_sum, lap, lh, ll, r;
		bit     ok;
		h = grid_height;
		if (h < MIN_HEIGHT) h = MIN_HEIGHT;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		win_line[win_head] = longint'($signed(cur));
		c = win_tap(2 * h);
		near_sum = win_tap(2 * h + 1) + win_tap(2 * h - 1) + win_tap(3 * h) + win_tap(h);
		far_sum = win_tap(2 * h + 2) + win_tap(2 * h - 2) + win_tap(4 * h)
			+ longint'($signed(cur));
		didx = (dly_head + DLY_DEPTH - 2 * h) % DLY_DEPTH;
		pc = prev_line[didx];
		vd = vel_line[didx];
		prev_line[dly_head] = longint'($signed(prv));
		vel_line[dly_head] = longint'(vel);
		lap = longint'(near_weight) * near_sum - far_sum + longint'(centre_weight) * c;
		lh = lap >>> 24;
		ll = lap - (lh <<< 24);
		// exact round half up of vel*lap / 2^24
		r = lh * vd + ((ll * vd + 64'sh800000) >>> 24);
		r = r + longint'(self_weight) * c - pc;
		res.sat = 0;
		if (r > 64'sh7FFFFFFF) begin
			r = 64'sh7FFFFFFF;
			res.sat = 1;
		end
		if (r < -64'sh80000000) begin
			r = -64'sh80000000;
			res.sat = 1;
		end
		row = row_ctr;
		col = (col_ctr - 2) & 16'hFFFF;
		ok = col_ctr >= 2 && col >= first_col && col < end_col
			&& row >= first_row && row < end_row;
		res.pressure = r[31:0];
		res.row = row[9:0];
		res.col = col[15:0];
		win_head = (win_head + 1) % WIN_DEPTH;
		dly_head = (dly_head + 1) % DLY_DEPTH;
		if (row_ctr + 1 >= h) begin
			row_ctr = 0;
			col_ctr = (col_ctr + 1) & 16'hFFFF;
		end else begin
			row_ctr++;
		end
		return ok;
	endfunction

	task automatic send_item(input logic [31:0] cur, input logic [31:0] prv,
			input logic [23:0] vel);
		int              gap;
		stencil_result_t res;
		gap = tx_steady ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {vel, prv, cur};
		do @(posedge clk); while (!s_tready);
		if (stencil_update(cur, prv, vel, res))
			pending_updates.push_back(res);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GRID_HEIGHT:   grid_height = val[10:0];
			REG_FIRST_COL:     first_col = val;
			REG_END_COL:       end_col = val;
			REG_FIRST_ROW:     first_row = val[9:0];
			REG_END_ROW:       end_row = val[10:0];
			REG_NEAR_WEIGHT:   near_weight = val[7:0];
			REG_CENTRE_WEIGHT: centre_weight = val[7:0];
			REG_SELF_WEIGHT:   self_weight = val[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// items may yield no result, so allow time for the last item after the queue drains
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_updates.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_window(input logic [15:0] fc, input logic [15:0] ec,
			input logic [9:0] fr, input logic [10:0] er);
		write_reg(REG_FIRST_COL, fc);
		write_reg(REG_END_COL, ec);
		write_reg(REG_FIRST_ROW, 16'(fr));
		write_reg(REG_END_ROW, 16'(er));
	endtask

	task automatic set_weights(input logic [7:0] nw, input logic [7:0] cw,
			input logic [3:0] sw);
		write_reg(REG_NEAR_WEIGHT, 16'(nw));
		write_reg(REG_CENTRE_WEIGHT, 16'(cw));
		write_reg(REG_SELF_WEIGHT, 16'(sw));
	endtask

	task automatic send_random(input int n);
		logic [31:0] cur, prv;
		logic [23:0] vel;
		repeat (n) begin
			cur = $urandom();
			prv = $urandom();
			// mostly moderate amplitudes so saturation stays the exception
			if ($urandom_range(0, 9) < 7) cur = {{12{cur[19]}}, cur[19:0]};
			if ($urandom_range(0, 9) < 7) prv = {{12{prv[19]}}, prv[19:0]};
			case ($urandom_range(0, 9))
				0: vel = 24'h0;
				1: vel = 24'hFFFFFF;
				default: vel = $urandom();
			endcase
			send_item(cur, prv, vel);
		end
	endtask

	task automatic test_field_extremes();
		logic [31:0] vals [6] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF,
			32'h00010000, 32'hFFFF0000};
		write_reg(REG_GRID_HEIGHT, 16'd5);
		set_window(16'd0, 16'd65535, 10'd0, 11'd1024);
		for (int i = 0; i < 24; i++)
			send_item(vals[i % 6], vals[(i + 3) % 6], (i % 3 == 0) ? 24'hFFFFFF :
				(i % 3 == 1) ? 24'h0 : 24'h800000);
		drain();
	endtask

	task automatic test_weight_extremes();
		set_weights(8'h80, 8'h7F, 4'h8);
		send_random(40);
		drain();
		set_weights(8'h7F, 8'h80, 4'h7);
		send_random(40);
		drain();
		set_weights(8'd16, 8'hC4, 4'd2);
	endtask

	task automatic test_height_and_window();
		// heights below the minimum and above the maximum clamp, mid-column height changes re-wrap the row
		write_reg(REG_GRID_HEIGHT, 16'd0);
		send_random(23);
		drain();
		write_reg(REG_GRID_HEIGHT, 16'd2047);
		send_random(30);
		drain();
		write_reg(REG_GRID_HEIGHT, 16'd1024);
		send_random(20);
		drain();
		write_reg(REG_GRID_HEIGHT, 16'd7);
		set_window(16'd5, 16'd5, 10'd0, 11'd1024);   // empty column range
		send_random(40);
		drain();
		set_window(16'd0, 16'd65535, 10'd1023, 11'd0); // empty row range
		send_random(30);
		drain();
		set_window(16'd3, 16'd9, 10'd1, 11'd6);
		send_random(60);
		drain();
	endtask

	task automatic test_backpressure();
		write_reg(REG_GRID_HEIGHT, 16'd5);
		set_window(16'd0, 16'd65535, 10'd0, 11'd1024);
		tx_steady = 1;
		rx_long_hold = 400;
		send_random(60);
		tx_steady = 0;
		drain();
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 16; ph++) begin
			int h;
			h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
			write_reg(REG_GRID_HEIGHT, 16'(h));
			set_window(16'($urandom_range(0, 6)), 16'($urandom_range(3, 65535)),
				10'($urandom_range(0, 3)), 11'($urandom_range(4, 14)));
			set_weights(8'($urandom()), 8'($urandom()), 4'($urandom()));
			tx_steady = (ph % 5 == 2);
			rx_steady = (ph % 5 == 3);
			send_random(46);
			drain();
		end
		tx_steady = 0;
		rx_steady = 0;
	endtask

	// receiver: per-result stall, plus a long hold when requested
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			n = 0;
			if (rx_long_hold > 0) begin
				n = rx_long_hold;
				rx_long_hold = 0;
			end else if (!rx_steady) begin
				n = $urandom_range(0, 18);
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			stencil_result_t exp_r;
			if (pending_updates.size() == 0) begin
				$error("unexpected result %h", m_tdata);
				errors++;
			end else begin
				exp_r = pending_updates.pop_front();
				if (m_tdata[31:0] !== exp_r.pressure) begin
					$error("new_pressure exp %h got %h", exp_r.pressure, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[41:32] !== exp_r.row) begin
					$error("row_index exp %0d got %0d", exp_r.row, m_tdata[41:32]);
					errors++;
				end
				if (m_tdata[57:42] !== exp_r.col) begin
					$error("col_index exp %0d got %0d", exp_r.col, m_tdata[57:42]);
					errors++;
				end
				if (m_tuser !== exp_r.sat) begin
					$error("saturated exp %b got %b", exp_r.sat, m_tuser);
					errors++;
				end
			end
		end
	end

	initial begin
		#6000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_GRID_HEIGHT;
		cfg_data = '0;
		for (int i = 0; i < WIN_DEPTH; i++) win_line[i] = 0;
		for (int i = 0; i < DLY_DEPTH; i++) begin
			prev_line[i] = 0;
			vel_line[i] = 0;
		end
		win_head = 0;
		dly_head = 0;
		row_ctr = 0;
		col_ctr = 0;
		grid_height = 11'd1024;
		first_col = 16'd2;
		end_col = 16'd65533;
		first_row = 10'd2;
		end_row = 11'd1022;
		near_weight = 8'sd16;
		centre_weight = -8'sd60;
		self_weight = 4'sd2;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_field_extremes();
		test_weight_extremes();
		test_height_and_window();
		test_backpressure();
		test_random_phases();
		if (errors == 0 && pending_updates.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (pending_updates.size() != 0) $error("%0d results missing", pending_updates.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
`default_nettype wire
